>>> rtl/lspd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lspd_pkg;

	localparam logic [2:0] ST_TAKEN    = 3'd0;
	localparam logic [2:0] ST_MISMATCH = 3'd1;
	localparam logic [2:0] ST_DECODED  = 3'd2;
	localparam logic [2:0] ST_ROUND    = 3'd3;
	localparam logic [2:0] ST_READ     = 3'd4;

	localparam logic REG_FRONT_LIMIT = 1'b0;
	localparam logic REG_REAR_LIMIT  = 1'b1;

	localparam logic [10:0] FRONT_LIMIT_RST = 11'd35;
	localparam logic [10:0] REAR_LIMIT_RST  = 11'd55;

	localparam logic [5:0]  QUALITY_KEEP = 6'd15;
	localparam logic [2:0]  PKT_LAST_POS = 3'd4;
	localparam logic [15:0] DIV5_RECIP   = 16'd52429;
	localparam logic [8:0]  FRONT_HI     = 9'd90;
	localparam logic [8:0]  FRONT_LO     = 9'd270;
	localparam logic [8:0]  FULL_TURN    = 9'd360;
	localparam int          OCT_SPAN     = 45;

	typedef struct packed {
		logic        en;
		logic [8:0]  addr;
		logic [10:0] data;
	} tbl_wr_t;

	function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0:    b = 8'hA5;
			3'd1:    b = 8'h5A;
			3'd2:    b = 8'h05;
			3'd3:    b = 8'h00;
			3'd4:    b = 8'h00;
			3'd5:    b = 8'h40;
			3'd6:    b = 8'h81;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [2:0] octant_of(input logic [8:0] ang);
		logic [2:0] k;
		k = 3'd0;
		for (int j = 1; j < 8; j++) begin
			if (ang > 9'(OCT_SPAN * j))
				k = k + 3'd1;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lspd_table.sv
`timescale 1ns / 1ps
`default_nettype none

module lspd_table #(
	parameter int NUM_ANGLES = 360
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [8:0]       rd_addr,
	input  wire lspd_pkg::tbl_wr_t wr,
	output logic      [10:0]      rd_data,
	output logic                  busy
);

	localparam int AW = $clog2(NUM_ANGLES);

	logic [10:0]   mem [NUM_ANGLES];
	logic [10:0]   ram_q;
	logic [10:0]   byp_data_q;
	logic          byp_q;
	logic          busy_q;
	logic [AW-1:0] clr_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [10:0]   wdata;

	always_comb begin
		if (busy_q) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = 11'd0;
		end else begin
			we    = wr.en;
			waddr = wr.addr[AW-1:0];
			wdata = wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en)
			ram_q <= mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
			byp_q  <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(NUM_ANGLES - 1))
					busy_q <= 1'b0;
			end
			if (rd_en)
				byp_q <= wr.en && (wr.addr[AW-1:0] == rd_addr[AW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			byp_data_q <= wr.data;
	end

	assign rd_data = byp_q ? byp_data_q : ram_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

>>> rtl/lidar_scan_packet_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream decoder for a scanning range sensor. Each transfer on the input
// channel is either one stream byte (action 0) or a distance-table read
// (action 1), and yields exactly one result transfer. One item is taken per
// clock cycle while in_ready is high, which needs the clearing sweep done and
// the output not stalled by out_ready; each result goes through the stage-1
// registers (header/packet sequencer, divide-by-5 multiply and table read)
// and then the result registers (table update and outputs). The table is a
// single-port-write, single-port-read memory of NUM_ANGLES entries; after
// reset it is swept to zero, and during the sweep in_ready stays low while
// configuration writes are taken as usual.
module lidar_scan_packet_decoder #(
	parameter int NUM_ANGLES   = 360,
	parameter int HEADER_BYTES = 7
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [10:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  data_byte,
	input  wire logic [8:0]  entry_index,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [2:0]  status,
	output logic      [8:0]  decoded_angle,
	output logic      [10:0] decoded_distance,
	output logic             kept,
	output logic      [7:0]  octant_flags,
	output logic      [8:0]  peak_angle,
	output logic      [10:0] peak_distance,
	output logic      [10:0] entry_value,
	output logic      [10:0] table_xor
);

	localparam int PW = $clog2(NUM_ANGLES);

	logic [10:0]   front_q;
	logic [10:0]   rear_q;

	logic          active_q;
	logic [2:0]    hpos_q;
	logic [2:0]    bpos_q;
	logic [PW-1:0] pcnt_q;
	logic [7:0]    pb0_q;
	logic [7:0]    pb1_q;
	logic [7:0]    pb2_q;
	logic [7:0]    pb3_q;

	logic          s1_valid_s1;
	logic [2:0]    status_s1;
	logic          pkt_s1;
	logic          inrange_s1;
	logic          q15_s1;
	logic          clr_oct_s1;
	logic          publish_s1;
	logic          read_s1;
	logic          rd_ok_s1;
	logic [8:0]    dang_s1;
	logic [28:0]   prod_s1;

	logic [7:0]    round_oct_q;
	logic [7:0]    shown_q;
	logic [10:0]   best_q;
	logic [8:0]    best_ang_q;
	logic [10:0]   xor_q;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [8:0]    dang_q;
	logic [10:0]   ddist_q;
	logic          kept_q;
	logic [10:0]   evalue_q;

	logic          busy;
	logic          adv;
	logic          accept;
	logic          step;
	logic [8:0]    dang_in;
	logic [12:0]   dist8_in;
	logic [8:0]    rd_addr;
	logic [10:0]   rd_data;
	lspd_pkg::tbl_wr_t wr;

	logic          hdr_match;
	logic          hdr_done;
	logic          pkt_done;
	logic          round_end;

	logic [10:0]   ddist;
	logic          kept_c;
	logic          front;
	logic          hit;
	logic [7:0]    oct_next;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !busy && (!s1_valid_s1 || adv);
	assign accept   = in_valid && in_ready;
	assign step     = s1_valid_s1 && adv;

	assign dang_in  = {pb2_q, pb1_q[7]};
	assign dist8_in = {data_byte, pb3_q[7:3]};
	assign rd_addr  = action ? entry_index : dang_in;

	assign hdr_match = ({1'b0, hpos_q} < 4'(HEADER_BYTES))
		&& (data_byte == lspd_pkg::hdr_byte(hpos_q));
	assign hdr_done  = ({1'b0, hpos_q} + 4'd1) >= 4'(HEADER_BYTES);
	assign pkt_done  = !action && active_q && (bpos_q == lspd_pkg::PKT_LAST_POS);
	assign round_end = pkt_done && (pcnt_q == PW'(NUM_ANGLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= lspd_pkg::FRONT_LIMIT_RST;
			rear_q  <= lspd_pkg::REAR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lspd_pkg::REG_FRONT_LIMIT: front_q <= cfg_data;
				lspd_pkg::REG_REAR_LIMIT:  rear_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// header and packet sequencer, advanced on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			hpos_q      <= 3'd0;
			bpos_q      <= 3'd0;
			pcnt_q      <= '0;
			s1_valid_s1 <= 1'b0;
			status_s1   <= lspd_pkg::ST_TAKEN;
			pkt_s1      <= 1'b0;
			clr_oct_s1  <= 1'b0;
			publish_s1  <= 1'b0;
			read_s1     <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_s1 <= 1'b1;
				pkt_s1      <= pkt_done;
				clr_oct_s1  <= 1'b0;
				publish_s1  <= 1'b0;
				read_s1     <= action;
				status_s1   <= lspd_pkg::ST_TAKEN;
				if (action) begin
					status_s1 <= lspd_pkg::ST_READ;
				end else if (!active_q) begin
					clr_oct_s1 <= !hdr_match || hdr_done;
					if (!hdr_match) begin
						status_s1 <= lspd_pkg::ST_MISMATCH;
						hpos_q    <= 3'd0;
					end else if (hdr_done) begin
						active_q <= 1'b1;
						hpos_q   <= 3'd0;
						bpos_q   <= 3'd0;
						pcnt_q   <= '0;
					end else begin
						hpos_q <= hpos_q + 3'd1;
					end
				end else if (!pkt_done) begin
					bpos_q <= bpos_q + 3'd1;
				end else begin
					bpos_q <= 3'd0;
					if (round_end) begin
						status_s1  <= lspd_pkg::ST_ROUND;
						publish_s1 <= 1'b1;
						active_q   <= 1'b0;
						pcnt_q     <= '0;
						hpos_q     <= 3'd0;
					end else begin
						status_s1 <= lspd_pkg::ST_DECODED;
						pcnt_q    <= pcnt_q + PW'(1);
					end
				end
			end else if (adv) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !action && active_q) begin
			case (bpos_q)
				3'd0:    pb0_q <= data_byte;
				3'd1:    pb1_q <= data_byte;
				3'd2:    pb2_q <= data_byte;
				3'd3:    pb3_q <= data_byte;
				default: ;
			endcase
		end
		if (accept) begin
			dang_s1    <= dang_in;
			inrange_s1 <= {1'b0, dang_in} < 10'(NUM_ANGLES);
			q15_s1     <= pb0_q[7:2] == lspd_pkg::QUALITY_KEEP;
			rd_ok_s1   <= {1'b0, entry_index} < 10'(NUM_ANGLES);
			prod_s1    <= dist8_in * lspd_pkg::DIV5_RECIP;
		end
	end

	lspd_table #(
		.NUM_ANGLES(NUM_ANGLES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.wr     (wr),
		.rd_data(rd_data),
		.busy   (busy)
	);

	always_comb begin
		ddist   = prod_s1[28:18];
		kept_c  = pkt_s1 && inrange_s1 && q15_s1;
		front   = (dang_s1 <= lspd_pkg::FRONT_HI) || (dang_s1 >= lspd_pkg::FRONT_LO);
		hit     = kept_c && (ddist != 11'd0) && (dang_s1 < lspd_pkg::FULL_TURN)
			&& (front ? (ddist < front_q) : (ddist < rear_q));
		wr.en   = step && pkt_s1 && inrange_s1;
		wr.addr = dang_s1;
		wr.data = q15_s1 ? ddist : 11'd0;
		if (clr_oct_s1)
			oct_next = 8'd0;
		else if (hit)
			oct_next = round_oct_q | (8'd1 << lspd_pkg::octant_of(dang_s1));
		else
			oct_next = round_oct_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_oct_q <= 8'd0;
			shown_q     <= 8'd0;
			best_q      <= 11'd0;
			best_ang_q  <= 9'd0;
			xor_q       <= 11'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				round_oct_q <= oct_next;
				if (publish_s1)
					shown_q <= oct_next;
				if (kept_c && (ddist > best_q)) begin
					best_q     <= ddist;
					best_ang_q <= dang_s1;
				end
				if (wr.en)
					xor_q <= xor_q ^ rd_data ^ wr.data;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_q <= status_s1;
			dang_q   <= pkt_s1 ? dang_s1 : 9'd0;
			ddist_q  <= pkt_s1 ? ddist : 11'd0;
			kept_q   <= kept_c;
			evalue_q <= (read_s1 && rd_ok_s1) ? rd_data : 11'd0;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign decoded_angle    = dang_q;
	assign decoded_distance = ddist_q;
	assign kept             = kept_q;
	assign octant_flags     = shown_q;
	assign peak_angle       = best_ang_q;
	assign peak_distance    = best_q;
	assign entry_value      = evalue_q;
	assign table_xor        = xor_q;

	a_publish_ends_round: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && publish_s1 |-> !active_q)
		else $error("round still active while its flags are published");

	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> best_q >= $past(best_q))
		else $error("peak distance decreased");

	a_no_work_during_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s1_valid_s1 && !wr.en)
		else $error("table update during clearing sweep");

	a_count_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> pcnt_q == '0)
		else $error("packet count nonzero outside a round");

endmodule

`default_nettype wire
